// File: sv/rcci_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcci_pkg
// Shared types, constants and fixed-point helpers for the capped cylinder
// intersection core.
// ----------------------------------------------------------------------------
package rcci_pkg;

	localparam int FRAC_BITS = 16;
	localparam int MASK_BITS = 16;

	localparam logic signed [31:0] FX_ONE  = 32'sd1 <<< FRAC_BITS;
	localparam logic signed [31:0] FX_HALF = FX_ONE >>> 1;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	localparam logic signed [63:0] L_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] L_MIN = -64'sh0000_0000_8000_0000;

	// part codes
	localparam logic [1:0] PART_SIDE   = 2'd0;
	localparam logic [1:0] PART_BOTTOM = 2'd1;
	localparam logic [1:0] PART_TOP    = 2'd2;

	// divider: quotient bits, bits per stage
	localparam int DIV_QW     = 32 + FRAC_BITS;
	localparam int DIV_STEP   = 4;
	localparam int DIV_STAGES = DIV_QW / DIV_STEP;
	localparam int DIV_LAT    = DIV_STAGES + 2;

	// square root: radicand bits, root bits per stage
	localparam int SQ_RW      = 32 + FRAC_BITS;
	localparam int SQ_ROOT_W  = SQ_RW / 2;
	localparam int SQ_REM_W   = SQ_ROOT_W + 2;
	localparam int SQ_STEP    = 4;
	localparam int SQ_STAGES  = SQ_ROOT_W / SQ_STEP;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
		logic [MASK_BITS-1:0] ray_type_mask;
	} rcci_in_t;

	typedef struct packed {
		logic               hit;
		logic [1:0]         hit_part;
		logic [30:0]        hit_distance;
		logic signed [31:0] normal_x;
		logic signed [31:0] normal_y;
		logic signed [31:0] normal_z;
	} rcci_out_t;

	// per-ray context carried down the pipe
	typedef struct packed {
		logic               mask_ok;
		logic               far;
		logic               side_ok;
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [31:0] oz;
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [31:0] dz;
		logic signed [31:0] a;
		logic signed [31:0] h;
	} rcci_ctx_t;

	typedef struct packed {
		logic [31:0]       rem;
		logic [DIV_QW-1:0] dvd;
		logic [DIV_QW-1:0] quo;
	} rcci_div_st_t;

	typedef struct packed {
		logic [SQ_REM_W-1:0]  rem;
		logic [SQ_ROOT_W-1:0] root;
		logic [SQ_RW-1:0]     rad;
	} rcci_sq_st_t;

	// product scaled down, rounding toward zero
	function automatic logic signed [63:0] fx_trunc(input logic signed [63:0] p);
		logic signed [63:0] bias;
		bias = p[63] ? $signed((64'd1 << FRAC_BITS) - 64'd1) : 64'sd0;
		return (p + bias) >>> FRAC_BITS;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > L_MAX) begin
			r = S32_MAX;
		end else if (v < L_MIN) begin
			r = S32_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] mag34(input logic signed [33:0] n);
		logic signed [33:0] m;
		m = n[33] ? -n : n;
		return m[31:0];
	endfunction

	// signed result from quotient magnitude, saturated
	function automatic logic signed [31:0] div_sat(input logic [DIV_QW-1:0] q,
			input logic neg);
		logic [DIV_QW-1:0] lim;
		logic signed [31:0] r;
		lim = DIV_QW'(33'h0_8000_0000);
		if (neg) begin
			r = (q > lim) ? S32_MIN : -$signed(q[31:0]);
		end else begin
			r = (q >= lim) ? S32_MAX : $signed(q[31:0]);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: sv/rcci_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcci_div
// Pipelined restoring divider: magnitude dividend shifted up by the fraction
// bits, four quotient bits per stage, signed saturated result.
// ----------------------------------------------------------------------------
module rcci_div import rcci_pkg::*; (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic [31:0]        num,
	input  wire logic [31:0]        den,
	input  wire logic               neg,
	output logic signed [31:0]      quo
);

	rcci_div_st_t dv_s0;
	logic [31:0]  den_s0;
	logic         neg_s0;

	rcci_div_st_t st_s  [1:DIV_STAGES];
	logic [31:0]  den_s [1:DIV_STAGES];
	logic         neg_s [1:DIV_STAGES];

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s0.rem <= '0;
			dv_s0.dvd <= {num, {FRAC_BITS{1'b0}}};
			dv_s0.quo <= '0;
			den_s0    <= den;
			neg_s0    <= neg;
		end
	end

	for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_stage
		rcci_div_st_t prv;
		rcci_div_st_t nxt;
		logic [31:0]  prv_den;
		logic         prv_neg;

		if (g == 1) begin : g_first
			assign prv     = dv_s0;
			assign prv_den = den_s0;
			assign prv_neg = neg_s0;
		end else begin : g_next
			assign prv     = st_s[g-1];
			assign prv_den = den_s[g-1];
			assign prv_neg = neg_s[g-1];
		end

		always_comb begin
			logic [32:0] r2;
			nxt = prv;
			for (int k = 0; k < DIV_STEP; k++) begin
				r2      = {nxt.rem, nxt.dvd[DIV_QW-1]};
				nxt.dvd = {nxt.dvd[DIV_QW-2:0], 1'b0};
				if (r2 >= {1'b0, prv_den}) begin
					nxt.rem = 32'(r2 - {1'b0, prv_den});
					nxt.quo = {nxt.quo[DIV_QW-2:0], 1'b1};
				end else begin
					nxt.rem = r2[31:0];
					nxt.quo = {nxt.quo[DIV_QW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[g]  <= nxt;
				den_s[g] <= prv_den;
				neg_s[g] <= prv_neg;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo <= div_sat(st_s[DIV_STAGES].quo, neg_s[DIV_STAGES]);
		end
	end

endmodule
`default_nettype wire

// File: sv/ray_capped_cylinder_intersect_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ray_capped_cylinder_intersect_core
// Local-space ray against a unit-radius cylinder about y, capped at y = +-1/2.
// Q16.16 throughout; side quadratic, pipelined square root and dividers.
// ----------------------------------------------------------------------------
//  port group   dir  handshake           word
//  in_*         in   in_valid/in_stall   rcci_in_t  ray origin, direction, mask
//  out_*        out  out_valid/out_stall rcci_out_t hit, part, distance, normal
//  cfg_*        in   cfg_valid/cfg_ready hit mask
//
//  one ray per cycle while not stalled, 29 register stages from input to output word
//  latency is set by the square root (6 stages) and the dividers (14 stages)
//  the whole pipe advances together; it freezes only while out_stall holds a
//  valid output word, and in_stall is high in exactly those cycles
//  reset clears the valid bits and sets the hit mask to all ones
// ----------------------------------------------------------------------------
module ray_capped_cylinder_intersect_core import rcci_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire rcci_in_t             in_word,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output rcci_out_t                 out_word,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [MASK_BITS-1:0] cfg_data
);

	logic                 en;
	logic [MASK_BITS-1:0] hit_mask_q;

	assign in_stall  = out_valid & out_stall;
	assign en        = ~in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_mask_q <= '1;
		end else if (cfg_valid) begin
			hit_mask_q <= cfg_data;
		end
	end

	// ---------------- valid bits ----------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s12, v_s27, v_s28;
	logic v_sq_s [1:SQ_STAGES];
	logic v_dv_s [1:DIV_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s12 <= 1'b0;
			v_s27 <= 1'b0;
			v_s28 <= 1'b0;
			out_valid <= 1'b0;
			for (int k = 1; k <= SQ_STAGES; k++) v_sq_s[k] <= 1'b0;
			for (int k = 1; k <= DIV_LAT; k++) v_dv_s[k] <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_sq_s[1] <= v_s5;
			for (int k = 2; k <= SQ_STAGES; k++) v_sq_s[k] <= v_sq_s[k-1];
			v_s12 <= v_sq_s[SQ_STAGES];
			v_dv_s[1] <= v_s12;
			for (int k = 2; k <= DIV_LAT; k++) v_dv_s[k] <= v_dv_s[k-1];
			v_s27 <= v_dv_s[DIV_LAT];
			v_s28 <= v_s27;
			out_valid <= v_s28;
		end
	end

	// ---------------- s1..s5: quadratic terms ----------------
	rcci_ctx_t ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5;
	rcci_ctx_t ctx_s3_d, ctx_s4_d, ctx_s5_d;
	logic signed [63:0] p_oxox_s2, p_ozoz_s2, p_dxdx_s2, p_dzdz_s2, p_oxdx_s2, p_ozdz_s2;
	logic signed [31:0] odist_s3;
	logic signed [63:0] p_hh_s4, p_ac_s4;
	logic signed [31:0] disc_s5;
	logic signed [63:0] c_s3;

	assign c_s3 = 64'(odist_s3) - 64'(FX_ONE);

	always_comb begin
		ctx_s3_d   = ctx_s2;
		ctx_s3_d.a = sat32(fx_trunc(p_dxdx_s2) + fx_trunc(p_dzdz_s2));
		ctx_s3_d.h = sat32(fx_trunc(p_oxdx_s2) + fx_trunc(p_ozdz_s2));

		ctx_s4_d     = ctx_s3;
		ctx_s4_d.far = odist_s3 >= FX_ONE;

		ctx_s5_d         = ctx_s4;
		ctx_s5_d.side_ok = (ctx_s4.a > 32'sd0)
			&& (sat32(fx_trunc(p_hh_s4) - fx_trunc(p_ac_s4)) >= 32'sd0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1.mask_ok <= |(in_word.ray_type_mask & hit_mask_q);
			ctx_s1.far     <= 1'b0;
			ctx_s1.side_ok <= 1'b0;
			ctx_s1.ox      <= in_word.origin_x;
			ctx_s1.oy      <= in_word.origin_y;
			ctx_s1.oz      <= in_word.origin_z;
			ctx_s1.dx      <= in_word.dir_x;
			ctx_s1.dy      <= in_word.dir_y;
			ctx_s1.dz      <= in_word.dir_z;
			ctx_s1.a       <= '0;
			ctx_s1.h       <= '0;

			ctx_s2    <= ctx_s1;
			p_oxox_s2 <= 64'(ctx_s1.ox) * 64'(ctx_s1.ox);
			p_ozoz_s2 <= 64'(ctx_s1.oz) * 64'(ctx_s1.oz);
			p_dxdx_s2 <= 64'(ctx_s1.dx) * 64'(ctx_s1.dx);
			p_dzdz_s2 <= 64'(ctx_s1.dz) * 64'(ctx_s1.dz);
			p_oxdx_s2 <= 64'(ctx_s1.ox) * 64'(ctx_s1.dx);
			p_ozdz_s2 <= 64'(ctx_s1.oz) * 64'(ctx_s1.dz);

			ctx_s3   <= ctx_s3_d;
			odist_s3 <= sat32(fx_trunc(p_oxox_s2) + fx_trunc(p_ozoz_s2));

			ctx_s4     <= ctx_s4_d;
			p_hh_s4    <= 64'(ctx_s3.h) * 64'(ctx_s3.h);
			p_ac_s4    <= 64'(ctx_s3.a) * c_s3;

			ctx_s5  <= ctx_s5_d;
			disc_s5 <= sat32(fx_trunc(p_hh_s4) - fx_trunc(p_ac_s4));
		end
	end

	// ---------------- square root of disc, four root bits a stage ----------------
	rcci_sq_st_t sq_in;
	rcci_sq_st_t sq_st_s  [1:SQ_STAGES];
	rcci_ctx_t   ctx_sq_s [1:SQ_STAGES];

	always_comb begin
		sq_in.rem  = '0;
		sq_in.root = '0;
		sq_in.rad  = SQ_RW'({disc_s5[30:0], {FRAC_BITS{1'b0}}});
	end

	for (genvar g = 1; g <= SQ_STAGES; g++) begin : g_sqrt
		rcci_sq_st_t prv;
		rcci_sq_st_t nxt;

		if (g == 1) begin : g_first
			assign prv = sq_in;
		end else begin : g_next
			assign prv = sq_st_s[g-1];
		end

		always_comb begin
			logic [SQ_REM_W+1:0] r2;
			logic [SQ_REM_W+1:0] trial;
			nxt = prv;
			for (int k = 0; k < SQ_STEP; k++) begin
				r2      = {nxt.rem, nxt.rad[SQ_RW-1 -: 2]};
				trial   = (SQ_REM_W+2)'({nxt.root, 2'b01});
				nxt.rad = {nxt.rad[SQ_RW-3:0], 2'b00};
				if (r2 >= trial) begin
					nxt.rem  = SQ_REM_W'(r2 - trial);
					nxt.root = {nxt.root[SQ_ROOT_W-2:0], 1'b1};
				end else begin
					nxt.rem  = r2[SQ_REM_W-1:0];
					nxt.root = {nxt.root[SQ_ROOT_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_st_s[g] <= nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_sq_s[1] <= ctx_s5;
			for (int k = 2; k <= SQ_STAGES; k++) ctx_sq_s[k] <= ctx_sq_s[k-1];
		end
	end

	// ---------------- s12: numerators and divisors ----------------
	rcci_ctx_t          ctx_s12;
	logic [31:0]        n1_mag_s12, n2_mag_s12, nb_mag_s12, nt_mag_s12;
	logic               n1_neg_s12, n2_neg_s12, nb_neg_s12, nt_neg_s12;
	logic [31:0]        den_side_s12, den_cap_s12;
	logic signed [33:0] n1, n2, nb, nt;
	rcci_ctx_t          ctx_q;

	assign ctx_q = ctx_sq_s[SQ_STAGES];

	always_comb begin
		n1 = -34'(ctx_q.h) - $signed(34'(sq_st_s[SQ_STAGES].root));
		n2 = -34'(ctx_q.h) + $signed(34'(sq_st_s[SQ_STAGES].root));
		nb = -34'(FX_HALF) - 34'(ctx_q.oy);
		nt = 34'(FX_HALF) - 34'(ctx_q.oy);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s12      <= ctx_q;
			n1_mag_s12   <= mag34(n1);
			n2_mag_s12   <= mag34(n2);
			nb_mag_s12   <= mag34(nb);
			nt_mag_s12   <= mag34(nt);
			n1_neg_s12   <= n1[33];
			n2_neg_s12   <= n2[33];
			nb_neg_s12   <= nb[33] ^ ctx_q.dy[31];
			nt_neg_s12   <= nt[33] ^ ctx_q.dy[31];
			den_side_s12 <= ctx_q.a;
			den_cap_s12  <= mag34(34'(ctx_q.dy));
		end
	end

	// ---------------- dividers ----------------
	logic signed [31:0] t1_dv, t2_dv, tb_dv, tt_dv;
	rcci_ctx_t          ctx_dv_s [1:DIV_LAT];

	rcci_div u_div_t1 (.clk(clk), .en(en), .num(n1_mag_s12), .den(den_side_s12),
		.neg(n1_neg_s12), .quo(t1_dv));
	rcci_div u_div_t2 (.clk(clk), .en(en), .num(n2_mag_s12), .den(den_side_s12),
		.neg(n2_neg_s12), .quo(t2_dv));
	rcci_div u_div_tb (.clk(clk), .en(en), .num(nb_mag_s12), .den(den_cap_s12),
		.neg(nb_neg_s12), .quo(tb_dv));
	rcci_div u_div_tt (.clk(clk), .en(en), .num(nt_mag_s12), .den(den_cap_s12),
		.neg(nt_neg_s12), .quo(tt_dv));

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_dv_s[1] <= ctx_s12;
			for (int k = 2; k <= DIV_LAT; k++) ctx_dv_s[k] <= ctx_dv_s[k-1];
		end
	end

	// ---------------- s27: side candidate products ----------------
	rcci_ctx_t          ctx_s27, ctx_s28;
	logic signed [31:0] t1_s27, t2_s27, tb_s27, tt_s27, tn_s27;
	logic signed [63:0] p_y_s27, p_x_s27, p_z_s27;
	logic signed [31:0] t1_s28, t2_s28, tb_s28, tt_s28, tn_s28;
	logic signed [31:0] y_s28, nx_s28, nz_s28;
	logic signed [31:0] tn;

	assign tn = (t1_dv >= 32'sd0) ? t1_dv : t2_dv;

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s27 <= ctx_dv_s[DIV_LAT];
			t1_s27  <= t1_dv;
			t2_s27  <= t2_dv;
			tb_s27  <= tb_dv;
			tt_s27  <= tt_dv;
			tn_s27  <= tn;
			p_y_s27 <= 64'(tn) * 64'(ctx_dv_s[DIV_LAT].dy);
			p_x_s27 <= 64'(ctx_dv_s[DIV_LAT].dx) * 64'(tn);
			p_z_s27 <= 64'(ctx_dv_s[DIV_LAT].dz) * 64'(tn);

			ctx_s28 <= ctx_s27;
			t1_s28  <= t1_s27;
			t2_s28  <= t2_s27;
			tb_s28  <= tb_s27;
			tt_s28  <= tt_s27;
			tn_s28  <= tn_s27;
			y_s28   <= sat32(64'(ctx_s27.oy) + fx_trunc(p_y_s27));
			nx_s28  <= sat32(64'(ctx_s27.ox) + fx_trunc(p_x_s27));
			nz_s28  <= sat32(64'(ctx_s27.oz) + fx_trunc(p_z_s27));
		end
	end

	// ---------------- result selection ----------------
	rcci_out_t res;

	always_comb begin
		logic               cap_go;
		logic               pick;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		logic signed [31:0] tc;
		logic [1:0]         part;
		res    = '0;
		cap_go = 1'b0;
		pick   = 1'b0;
		lo     = 32'sd0;
		hi     = S32_MAX;
		tc     = 32'sd0;
		part   = PART_SIDE;
		if (ctx_s28.mask_ok && (ctx_s28.side_ok || !ctx_s28.far)) begin
			cap_go = 1'b1;
			if (ctx_s28.side_ok) begin
				if (t2_s28 < 32'sd0) begin
					cap_go = 1'b0;
				end else if (y_s28 >= -FX_HALF && y_s28 <= FX_HALF) begin
					cap_go           = 1'b0;
					res.hit          = 1'b1;
					res.hit_part     = PART_SIDE;
					res.hit_distance = tn_s28[30:0];
					res.normal_x     = nx_s28;
					res.normal_z     = nz_s28;
				end else begin
					lo = (t1_s28 >= 32'sd0) ? t1_s28 : 32'sd0;
					hi = t2_s28;
				end
			end
			if (cap_go && ctx_s28.dy != 32'sd0) begin
				// bottom wins a tie
				if (tb_s28 >= 32'sd0 && (tt_s28 < 32'sd0 || tb_s28 <= tt_s28)) begin
					pick = 1'b1;
					tc   = tb_s28;
					part = PART_BOTTOM;
				end else if (tt_s28 >= 32'sd0) begin
					pick = 1'b1;
					tc   = tt_s28;
					part = PART_TOP;
				end
				if (pick && tc >= lo && tc <= hi) begin
					res.hit          = 1'b1;
					res.hit_part     = part;
					res.hit_distance = tc[30:0];
					res.normal_y     = (part == PART_BOTTOM) ? -FX_ONE : FX_ONE;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_word <= res;
		end
	end

	// ---------------- assertions ----------------
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.hit |-> out_word == '0)
		else $error("miss word carries nonzero fields");

	a_part_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_word.hit_part == PART_SIDE || out_word.hit_part == PART_BOTTOM
			|| out_word.hit_part == PART_TOP))
		else $error("bad hit part");

	a_cap_normal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.hit && out_word.hit_part != PART_SIDE |->
			out_word.normal_x == 32'sd0 && out_word.normal_z == 32'sd0
			&& (out_word.normal_y == FX_ONE || out_word.normal_y == -FX_ONE))
		else $error("cap hit with wrong normal");

	a_side_normal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.hit && out_word.hit_part == PART_SIDE |->
			out_word.normal_y == 32'sd0)
		else $error("side hit with nonzero normal y");

endmodule
`default_nettype wire

// File: tb/sv/ray_capped_cylinder_intersect_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_capped_cylinder_intersect_core_tb
// Streams rays through the capped cylinder core. A directed table comes first,
// then random rays. Every output word is compared with a predicted word taken
// from a fixed-point predictor, in order. The hit mask is changed while idle.
// ----------------------------------------------------------------------------
module ray_capped_cylinder_intersect_core_tb;
	import rcci_pkg::*;

	localparam int PIPE_LAT = 29;
	localparam int WDOG_LIMIT = 20000;
	localparam int N_RANDOM = 1750;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	rcci_in_t in_word;
	logic out_valid;
	logic out_stall;
	rcci_out_t out_word;
	logic cfg_valid;
	logic cfg_ready;
	logic [MASK_BITS-1:0] cfg_data;

	rcci_out_t hits_pending[$];
	logic [15:0] mask_now;
	int mismatches;
	int idle_cycles;
	bit src_bursty;
	bit sink_bursty;
	int sink_hold;

	ray_capped_cylinder_intersect_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint sat_s32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// fixed-point multiply and divide, truncating toward zero
	function automatic longint qmul(input longint p, input longint q);
		return (p * q) / 65536;
	endfunction

	function automatic longint qdiv(input longint n, input longint d);
		return sat_s32((n * 65536) / d);
	endfunction

	function automatic longint root_floor(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return longint'(r);
	endfunction

	function automatic rcci_out_t make_word(input logic h, input logic [1:0] pt,
			input longint t, input longint nx, input longint ny, input longint nz);
		rcci_out_t w;
		w.hit = h;
		w.hit_part = pt;
		w.hit_distance = t[30:0];
		w.normal_x = nx[31:0];
		w.normal_y = ny[31:0];
		w.normal_z = nz[31:0];
		return w;
	endfunction

	function automatic rcci_out_t cylinder_hit(input rcci_in_t r, input logic [15:0] m);
		longint ox, oy, oz, dx, dy, dz;
		longint odist, a, h, c, disc, lo, hi, tb, tt, tc, rt, t1, t2, tn, y;
		logic [1:0] pt;
		rcci_out_t miss;
		miss = '0;
		ox = r.origin_x; oy = r.origin_y; oz = r.origin_z;
		dx = r.dir_x; dy = r.dir_y; dz = r.dir_z;
		if ((r.ray_type_mask & m) == 0) return miss;
		odist = sat_s32(qmul(ox, ox) + qmul(oz, oz));
		a = sat_s32(qmul(dx, dx) + qmul(dz, dz));
		h = sat_s32(qmul(ox, dx) + qmul(oz, dz));
		c = odist - 65536;
		disc = sat_s32(qmul(h, h) - qmul(a, c));
		if (!(a > 0 && disc >= 0)) begin
			if (odist >= 65536) return miss;
			lo = 0;
			hi = 64'sd2147483647;
		end else begin
			rt = root_floor(longint'(disc) << 16);
			t1 = qdiv(-h - rt, a);
			t2 = qdiv(-h + rt, a);
			if (t2 < 0) return miss;
			tn = (t1 >= 0) ? t1 : t2;
			y = sat_s32(oy + qmul(tn, dy));
			if (y >= -32768 && y <= 32768)
				return make_word(1'b1, PART_SIDE, tn, sat_s32(ox + qmul(dx, tn)), 0,
					sat_s32(oz + qmul(dz, tn)));
			lo = (t1 >= 0) ? t1 : 0;
			hi = t2;
		end
		if (dy == 0) return miss;
		tb = qdiv(-32768 - oy, dy);
		tt = qdiv(32768 - oy, dy);
		if (tb >= 0 && (tt < 0 || tb <= tt)) begin
			tc = tb;
			pt = PART_BOTTOM;
		end else if (tt >= 0) begin
			tc = tt;
			pt = PART_TOP;
		end else begin
			return miss;
		end
		if (tc < lo || tc > hi) return miss;
		return make_word(1'b1, pt, tc, 0, (pt == PART_BOTTOM) ? -65536 : 65536, 0);
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		mismatches++;
	endtask

	// checker and sink stall
	always @(posedge clk) begin
		rcci_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (hits_pending.size() == 0) begin
				report_mismatch("unexpected word", out_word, 0);
			end else begin
				want = hits_pending.pop_front();
				if (out_word.hit !== want.hit)
					report_mismatch("hit", out_word.hit, want.hit);
				if (out_word.hit_part !== want.hit_part)
					report_mismatch("hit_part", out_word.hit_part, want.hit_part);
				if (out_word.hit_distance !== want.hit_distance)
					report_mismatch("hit_distance", out_word.hit_distance, want.hit_distance);
				if (out_word.normal_x !== want.normal_x)
					report_mismatch("normal_x", out_word.normal_x, want.normal_x);
				if (out_word.normal_y !== want.normal_y)
					report_mismatch("normal_y", out_word.normal_y, want.normal_y);
				if (out_word.normal_z !== want.normal_z)
					report_mismatch("normal_z", out_word.normal_z, want.normal_z);
			end
		end
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (sink_hold > 0) begin
			out_stall <= 1'b1;
			sink_hold--;
		end else if (sink_bursty && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			sink_hold = $urandom_range(0, 6);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog on cycles with no accepted word
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WDOG_LIMIT) begin
			$display("[ray_capped_cylinder_intersect_core] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_ray(input rcci_in_t r);
		int gap;
		if (src_bursty && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 7);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		hits_pending.push_back(cylinder_hit(r, mask_now));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (hits_pending.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 4) @(posedge clk);
	endtask

	task automatic write_mask(input logic [15:0] m);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		mask_now = m;
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'h0;
			2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 262144)) - 131072);
		endcase
	endfunction

	function automatic rcci_in_t rand_ray();
		rcci_in_t r;
		r.origin_x = rand_coord();
		r.origin_y = rand_coord();
		r.origin_z = rand_coord();
		r.dir_x = rand_coord();
		r.dir_y = rand_coord();
		r.dir_z = rand_coord();
		r.ray_type_mask = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'hFFFF;
		return r;
	endfunction

	// aimed ray: origin near the cylinder, direction toward the axis
	function automatic rcci_in_t aimed_ray();
		rcci_in_t r;
		r.origin_x = 32'($signed($urandom_range(0, 393216)) - 196608);
		r.origin_y = 32'($signed($urandom_range(0, 196608)) - 98304);
		r.origin_z = 32'($signed($urandom_range(0, 393216)) - 196608);
		r.dir_x = -(r.origin_x >>> 1) + 32'($signed($urandom_range(0, 32768)) - 16384);
		r.dir_y = 32'($signed($urandom_range(0, 131072)) - 65536);
		r.dir_z = -(r.origin_z >>> 1) + 32'($signed($urandom_range(0, 32768)) - 16384);
		r.ray_type_mask = 16'($urandom) | 16'h1;
		return r;
	endfunction

	typedef struct {
		rcci_in_t ray;
		bit known;
		rcci_out_t want;
	} dir_row_t;

	localparam rcci_out_t MISS = '0;

	dir_row_t dir_rows[] = '{
		'{'{32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0, 16'h0}, 1, MISS},
		'{'{-32'h30000, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0, 16'h1}, 1,
			'{1'b1, PART_SIDE, 31'h20000, -32'h10000, 32'h0, 32'h0}},
		'{'{32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0, 16'h8000}, 1,
			'{1'b1, PART_SIDE, 31'h10000, 32'h10000, 32'h0, 32'h0}},
		'{'{32'h0, -32'h20000, 32'h0, 32'h0, 32'h10000, 32'h0, 16'hFFFF}, 1,
			'{1'b1, PART_BOTTOM, 31'h18000, 32'h0, -32'h10000, 32'h0}},
		'{'{32'h0, 32'h20000, 32'h0, 32'h0, -32'h10000, 32'h0, 16'hFFFF}, 1,
			'{1'b1, PART_TOP, 31'h18000, 32'h0, 32'h10000, 32'h0}},
		'{'{32'h0, 32'h20000, 32'h0, 32'h0, 32'h10000, 32'h0, 16'hFFFF}, 1, MISS},
		'{'{32'h30000, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 16'hFFFF}, 1, MISS},
		'{'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'hFFFF}, 1, MISS},
		'{'{32'h30000, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0, 16'hFFFF}, 1, MISS},
		'{'{32'h0, 32'h0, 32'h0, 32'h10000, 32'h20000, 32'h0, 16'hFFFF}, 0, MISS},
		'{'{32'h0, 32'h0, 32'h0, 32'h10000, 32'h8000, 32'h0, 16'hFFFF}, 0, MISS},
		'{'{-32'h30000, 32'h0, 32'h0, 32'h10000, 32'h10000, 32'h0, 16'hFFFF}, 0, MISS},
		'{'{32'h0, 32'h0, -32'h30000, 32'h0, 32'h0, 32'h10000, 16'hFFFF}, 0, MISS},
		'{'{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 16'hFFFF}, 0, MISS},
		'{'{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 16'hFFFF}, 0, MISS},
		'{'{32'h0, 32'h80000000, 32'h0, 32'h0, 32'h7FFFFFFF, 32'h0, 16'hFFFF}, 0, MISS},
		'{'{32'h8000, 32'h0, 32'h8000, 32'h80000000, 32'h1, 32'h7FFFFFFF, 16'hFFFF}, 0, MISS},
		'{'{32'hFFFFFFFF, 32'h1, 32'hFFFFFFFF, 32'h1, 32'hFFFFFFFF, 32'h1, 16'hFFFF}, 0, MISS}
	};

	initial begin
		rcci_in_t r;
		rcci_out_t got_want;
		int n;
		int hold;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		out_stall = 1'b0;
		mismatches = 0;
		idle_cycles = 0;
		sink_hold = 0;
		src_bursty = 1'b0;
		sink_bursty = 1'b0;
		mask_now = 16'hFFFF;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at reset mask
		foreach (dir_rows[i]) begin
			send_ray(dir_rows[i].ray);
			if (dir_rows[i].known) begin
				got_want = hits_pending[$];
				if (got_want !== dir_rows[i].want)
					report_mismatch("directed predictor row", i, 0);
				hits_pending[$] = dir_rows[i].want;
			end
		end
		drain();

		// mask extremes
		write_mask(16'h0000);
		send_ray(dir_rows[2].ray);
		send_ray(rand_ray());
		drain();
		write_mask(16'h8001);
		send_ray(dir_rows[1].ray);
		send_ray(dir_rows[2].ray);
		send_ray(dir_rows[3].ray);
		drain();
		write_mask(16'hFFFF);

		// random part with burst idling on both sides
		src_bursty = 1'b1;
		sink_bursty = 1'b1;
		n = 0;
		for (int ph = 0; ph < 5; ph++) begin
			for (int k = 0; k < 300; k++) begin
				send_ray(($urandom_range(0, 9) < 7) ? aimed_ray() : rand_ray());
				n++;
			end
			if (ph == 1) begin
				// long receiver hold-off while rays keep coming
				sink_hold = 80;
				for (int k = 0; k < 60; k++) begin
					send_ray(aimed_ray());
					n++;
				end
			end
			drain();
			write_mask(16'($urandom));
		end
		write_mask(16'hFFFF);

		// closing stretch without idling
		src_bursty = 1'b0;
		sink_bursty = 1'b0;
		while (n < N_RANDOM) begin
			send_ray(($urandom_range(0, 9) < 7) ? aimed_ray() : rand_ray());
			n++;
		end
		in_valid <= 1'b0;
		hold = 0;
		while (hits_pending.size() != 0 && hold < WDOG_LIMIT) begin
			@(posedge clk);
			hold++;
		end
		repeat (PIPE_LAT + 4) @(posedge clk);
		if (mismatches == 0 && hits_pending.size() == 0) begin
			$display("[ray_capped_cylinder_intersect_core] OK");
		end else begin
			$display("[ray_capped_cylinder_intersect_core] ERROR");
		end
		$finish;
	end

endmodule
